>>> sv/wed_pkg.sv
// wed_pkg: shared constants, opcode enum and request/result structs for word_edit_distance.
// No dependencies; imported by wed_cell and word_edit_distance.
package wed_pkg;

  localparam int MAX_WORDS    = 256;
  localparam int WORD_BITS    = 32;
  localparam int WORD_FIELD_W = 32;
  localparam int DIST_W       = 9;

  // identifier bits that take part in the compare
  localparam int KEY_W  = (WORD_BITS < WORD_FIELD_W) ? WORD_BITS : WORD_FIELD_W;
  // counts and row index run 0..MAX_WORDS
  localparam int IDX_W  = $clog2(MAX_WORDS + 1);
  // sweep issue pointer runs to MAX_WORDS + 1
  localparam int CNT_W  = $clog2(MAX_WORDS + 2);
  // row entries plus one for the min3 candidates
  localparam int DP_W   = $clog2(MAX_WORDS + 2);
  localparam int HYP_AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_REF    = 2'd2,
    OP_FINISH = 2'd3
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic [WORD_FIELD_W-1:0] word;
  } req_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              overflow;
  } res_t;

endpackage

>>> sv/wed_cell.sv
// wed_cell: one Levenshtein cell, min of above+1, left+1 and diag+substitution cost.
// Depends on wed_pkg for widths.
module wed_cell (
  input  logic [wed_pkg::DP_W-1:0]  above,
  input  logic [wed_pkg::DP_W-1:0]  left,
  input  logic [wed_pkg::DP_W-1:0]  diag,
  input  logic [wed_pkg::KEY_W-1:0] hyp_key,
  input  logic [wed_pkg::KEY_W-1:0] ref_key,
  output logic [wed_pkg::DP_W-1:0]  value
);
  import wed_pkg::*;

  logic [DP_W-1:0] up_cost;
  logic [DP_W-1:0] left_cost;
  logic [DP_W-1:0] diag_cost;
  logic [DP_W-1:0] m;

  always_comb begin
    up_cost   = above + DP_W'(1);
    left_cost = left + DP_W'(1);
    diag_cost = diag + ((hyp_key != ref_key) ? DP_W'(1) : DP_W'(0));
    m         = (up_cost < left_cost) ? up_cost : left_cost;
    value     = (m < diag_cost) ? m : diag_cost;
  end

endmodule

>>> sv/word_edit_distance.sv
// word_edit_distance: word-level Levenshtein distance with hypothesis and DP row in RAM.
// Depends on wed_pkg and wed_cell.
//
//   channel | signals                   | carries
//   --------+---------------------------+-------------------------------
//   request | req_valid, req_stall, req | op + word identifier (req_t)
//   result  | res_valid, res_stall, res | distance + overflow (res_t)
//
// Clear, append and dropped words are handled in ST_IDLE. A reference word is swept in
// ST_SWEEP: the row RAM gives one entry per cycle and each entry is read, updated and
// written back in turn. Finish reads the last row entry, then waits in ST_FIN on res_stall.
// Synchronous reset clears counters and control only; RAM contents are not cleared.
// A waiting result does not block requests other than the next finish.
module word_edit_distance (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  wed_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_stall,
  output wed_pkg::res_t res
);
  import wed_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SWEEP = 3'b010,
    ST_FIN   = 3'b100
  } state_t;

  state_t            state, state_next;
  logic [IDX_W-1:0]  hyp_count, hyp_count_next;
  logic [IDX_W-1:0]  ref_count, ref_count_next;
  logic              drop, drop_next;
  logic [KEY_W-1:0]  ref_word, ref_word_next;
  logic [CNT_W-1:0]  rd_idx, rd_idx_next;
  logic              p_vld, p_vld_next;
  logic [IDX_W-1:0]  p_idx, p_idx_next;
  logic [DP_W-1:0]   left, left_next;
  logic [DP_W-1:0]   diag, diag_next;
  logic              res_valid_next;
  logic              res_load;

  logic [KEY_W-1:0]  hyp_mem [MAX_WORDS];
  logic [DP_W-1:0]   dp_mem  [MAX_WORDS + 1];

  logic              hyp_we, hyp_re;
  logic [HYP_AW-1:0] hyp_waddr, hyp_raddr;
  logic [KEY_W-1:0]  hyp_wdata, hyp_rdata;
  logic              dp_we, dp_re;
  logic [IDX_W-1:0]  dp_waddr, dp_raddr;
  logic [DP_W-1:0]   dp_wdata, dp_rdata;

  logic              accept;
  logic [KEY_W-1:0]  req_key;
  logic [IDX_W-1:0]  hyp_inc;
  logic [CNT_W-1:0]  rd_prev;
  logic [DP_W-1:0]   cell_value;
  logic              dist_sat;

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != ST_IDLE);
  assign req_key   = req.word[KEY_W-1:0];
  assign hyp_inc   = hyp_count + IDX_W'(1);
  assign rd_prev   = rd_idx - CNT_W'(1);

  wed_cell u_cell (
    .above   (dp_rdata),
    .left    (left),
    .diag    (diag),
    .hyp_key (hyp_rdata),
    .ref_key (ref_word),
    .value   (cell_value)
  );

  always_comb begin
    state_next     = state;
    hyp_count_next = hyp_count;
    ref_count_next = ref_count;
    drop_next      = drop;
    ref_word_next  = ref_word;
    rd_idx_next    = rd_idx;
    p_vld_next     = 1'b0;
    p_idx_next     = p_idx;
    left_next      = left;
    diag_next      = diag;
    res_load       = 1'b0;
    hyp_we         = 1'b0;
    hyp_waddr      = hyp_count[HYP_AW-1:0];
    hyp_wdata      = req_key;
    hyp_re         = 1'b0;
    hyp_raddr      = rd_prev[HYP_AW-1:0];
    dp_we          = 1'b0;
    dp_waddr       = '0;
    dp_wdata       = '0;
    dp_re          = 1'b0;
    dp_raddr       = rd_idx[IDX_W-1:0];

    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (req.op)
            OP_CLEAR: begin
              hyp_count_next = '0;
              ref_count_next = '0;
              drop_next      = 1'b0;
              dp_we          = 1'b1;
              dp_waddr       = '0;
              dp_wdata       = '0;
            end
            OP_APPEND: begin
              if (ref_count != '0 || hyp_count == IDX_W'(MAX_WORDS)) begin
                drop_next = 1'b1;
              end else begin
                hyp_we         = 1'b1;
                dp_we          = 1'b1;
                dp_waddr       = hyp_inc;
                dp_wdata       = DP_W'(hyp_inc);
                hyp_count_next = hyp_inc;
              end
            end
            OP_REF: begin
              if (ref_count == IDX_W'(MAX_WORDS)) begin
                drop_next = 1'b1;
              end else begin
                ref_count_next = ref_count + IDX_W'(1);
                ref_word_next  = req_key;
                dp_re          = 1'b1;
                dp_raddr       = '0;
                p_vld_next     = 1'b1;
                p_idx_next     = '0;
                rd_idx_next    = CNT_W'(1);
                state_next     = ST_SWEEP;
              end
            end
            OP_FINISH: begin
              dp_re      = 1'b1;
              dp_raddr   = hyp_count;
              state_next = ST_FIN;
            end
            default: ;
          endcase
        end
      end
      ST_SWEEP: begin
        // read entry rd_idx while entry p_idx is written back
        if (rd_idx <= CNT_W'(hyp_count)) begin
          dp_re       = 1'b1;
          hyp_re      = 1'b1;
          p_vld_next  = 1'b1;
          p_idx_next  = rd_idx[IDX_W-1:0];
          rd_idx_next = rd_idx + CNT_W'(1);
        end
        if (p_vld) begin
          dp_we     = 1'b1;
          dp_waddr  = p_idx;
          diag_next = dp_rdata;
          if (p_idx == '0) begin
            dp_wdata  = DP_W'(ref_count);
            left_next = DP_W'(ref_count);
          end else begin
            dp_wdata  = cell_value;
            left_next = cell_value;
          end
          if (p_idx == hyp_count) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_FIN: begin
        if (!res_valid || !res_stall) begin
          res_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (res_load) begin
      res_valid_next = 1'b1;
    end else if (res_valid && !res_stall) begin
      res_valid_next = 1'b0;
    end else begin
      res_valid_next = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      hyp_count <= '0;
      ref_count <= '0;
      drop      <= 1'b0;
      p_vld     <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      hyp_count <= hyp_count_next;
      ref_count <= ref_count_next;
      drop      <= drop_next;
      p_vld     <= p_vld_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    ref_word <= ref_word_next;
    rd_idx   <= rd_idx_next;
    p_idx    <= p_idx_next;
    left     <= left_next;
    diag     <= diag_next;
  end

  // clamp only matters when the row is wider than the distance field
  assign dist_sat = (dp_rdata > DP_W'({DIST_W{1'b1}}));

  always_ff @(posedge clk) begin
    if (res_load) begin
      res.distance <= dist_sat ? {DIST_W{1'b1}} : DIST_W'(dp_rdata);
      res.overflow <= drop;
    end
  end

  always_ff @(posedge clk) begin
    if (hyp_we) begin
      hyp_mem[hyp_waddr] <= hyp_wdata;
    end
    if (hyp_re) begin
      hyp_rdata <= hyp_mem[hyp_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (dp_we) begin
      dp_mem[dp_waddr] <= dp_wdata;
    end
    if (dp_re) begin
      dp_rdata <= dp_mem[dp_raddr];
    end
  end

endmodule
